[hw/rtl/asd_pkg.sv]
// Shared types and constants of the accelerometer step detector.
`timescale 1ns / 1ps
package asd_pkg;

	localparam int unsigned AXIS_W   = 16;
	localparam int unsigned SUM_W    = 32;
	localparam int unsigned TIME_W   = 32;
	localparam int unsigned LEVEL_W  = 16;
	localparam int unsigned SCALED_W = 20;
	localparam int unsigned PROD_W   = 40;
	localparam int unsigned FIFO_DEPTH = 2;

	localparam logic [LEVEL_W-1:0]  GRAVITY_Q88 = 16'd2509;
	localparam logic [LEVEL_W-1:0]  MAG_MAX     = 16'd56755;
	// ceil(2^23 / 10): exact division by ten for dividends below 2^20
	localparam logic [SCALED_W-1:0] RECIP_TEN   = 20'd838861;
	localparam int unsigned         RECIP_SHIFT = 23;
	localparam logic [SUM_W-1:0]    ROOT_BIT_TOP = 32'h4000_0000;

	localparam logic [2:0] REG_LIFT     = 3'd0;
	localparam logic [2:0] REG_AIR      = 3'd1;
	localparam logic [2:0] REG_IMPACT   = 3'd2;
	localparam logic [2:0] REG_DEBOUNCE = 3'd3;
	localparam logic [2:0] REG_COOLDOWN = 3'd4;

	typedef enum logic [1:0] {
		PH_STABLE = 2'd0,
		PH_LIFT   = 2'd1,
		PH_AIR    = 2'd2
	} gait_phase_t;

	typedef struct packed {
		logic [TIME_W-1:0] now_ms;
		logic [SUM_W-1:0]  sum_sq;
	} sample_t;

	typedef struct packed {
		logic [LEVEL_W-1:0] lift_level;
		logic [LEVEL_W-1:0] air_level;
		logic [LEVEL_W-1:0] impact_level;
		logic [LEVEL_W-1:0] debounce_ms;
		logic [LEVEL_W-1:0] cooldown_ms;
	} cfg_t;

endpackage

[hw/rtl/asd_front.sv]
// Front end: accepts samples and forms the sum of squares with one multiplier.
`timescale 1ns / 1ps
module asd_front
	import asd_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [79:0]        s_tdata,
	input  logic               fifo_full,
	output logic               fifo_push,
	output sample_t            fifo_data
);

	typedef enum logic [1:0] {
		FR_IDLE,
		FR_SQUARE,
		FR_PUSH
	} front_state_t;

	front_state_t        state_q;
	logic [1:0]          cnt_q;
	logic [AXIS_W-1:0]   ax_q;
	logic [AXIS_W-1:0]   ay_q;
	logic [AXIS_W-1:0]   az_q;
	logic [TIME_W-1:0]   now_q;
	logic [SUM_W-1:0]    prod_q;
	logic [SUM_W-1:0]    acc_q;
	logic [AXIS_W-1:0]   axis_sel;
	logic [AXIS_W-1:0]   axis_mag;

	assign s_tready  = (state_q == FR_IDLE);
	assign fifo_push = (state_q == FR_PUSH) && !fifo_full;
	assign fifo_data = '{now_ms: now_q, sum_sq: acc_q + prod_q};

	always_comb begin
		unique case (cnt_q)
			2'd0:    axis_sel = ax_q;
			2'd1:    axis_sel = ay_q;
			default: axis_sel = az_q;
		endcase
	end

	// Magnitude of a two's complement value; the most negative one maps to 32768.
	assign axis_mag = axis_sel[AXIS_W-1] ? (~axis_sel + 16'd1) : axis_sel;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FR_IDLE;
			cnt_q   <= '0;
		end else begin
			unique case (state_q)
				FR_IDLE: begin
					if (s_tvalid) begin
						state_q <= FR_SQUARE;
						cnt_q   <= '0;
					end
				end
				FR_SQUARE: begin
					cnt_q <= cnt_q + 2'd1;
					if (cnt_q == 2'd2) begin
						state_q <= FR_PUSH;
					end
				end
				FR_PUSH: begin
					if (!fifo_full) begin
						state_q <= FR_IDLE;
					end
				end
				default: state_q <= FR_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == FR_IDLE && s_tvalid) begin
			ax_q  <= s_tdata[15:0];
			ay_q  <= s_tdata[31:16];
			az_q  <= s_tdata[47:32];
			now_q <= s_tdata[79:48];
		end
		if (state_q == FR_SQUARE) begin
			prod_q <= SUM_W'(axis_mag) * SUM_W'(axis_mag);
			acc_q  <= (cnt_q == 2'd0) ? '0 : acc_q + prod_q;
		end
	end

endmodule

[hw/rtl/asd_fifo.sv]
// Two-entry queue between the front end and the back end.
`timescale 1ns / 1ps
module asd_fifo
	import asd_pkg::*;
(
	input  logic    clk,
	input  logic    arst_n,
	input  logic    push,
	input  sample_t push_data,
	output logic    full,
	input  logic    pop,
	output logic    empty,
	output sample_t pop_data
);

	sample_t mem_q [FIFO_DEPTH];
	logic    wr_ptr_q;
	logic    rd_ptr_q;
	logic [1:0] count_q;

	assign full     = (count_q == 2'(FIFO_DEPTH));
	assign empty    = (count_q == 2'd0);
	assign pop_data = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= '0;
		end else begin
			if (push && !full) begin
				wr_ptr_q <= ~wr_ptr_q;
			end
			if (pop && !empty) begin
				rd_ptr_q <= ~rd_ptr_q;
			end
			if ((push && !full) && !(pop && !empty)) begin
				count_q <= count_q + 2'd1;
			end else if (!(push && !full) && (pop && !empty)) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push && !full) begin
			mem_q[wr_ptr_q] <= push_data;
		end
	end

endmodule

[hw/rtl/asd_back.sv]
// Back end: bit-serial square root, smoothing filter, gait phase machine and result register.
`timescale 1ns / 1ps
module asd_back
	import asd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        fifo_empty,
	input  sample_t     fifo_data,
	output logic        fifo_pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata
);

	typedef enum logic [2:0] {
		BK_IDLE,
		BK_ROOT,
		BK_SCALE,
		BK_DIV,
		BK_COMMIT
	} back_state_t;

	back_state_t         state_q;
	logic [3:0]          iter_q;
	logic [SUM_W-1:0]    rem_q;
	logic [SUM_W-1:0]    root_q;
	logic [SUM_W-1:0]    bit_q;
	logic [TIME_W-1:0]   now_q;
	logic [SCALED_W-1:0] scaled_q;
	logic [LEVEL_W-1:0]  quot_q;

	logic [LEVEL_W-1:0]  filt_q;
	gait_phase_t         phase_q;
	logic [TIME_W-1:0]   entry_q;
	logic [TIME_W-1:0]   last_step_q;

	logic                out_valid_q;
	logic [LEVEL_W-1:0]  out_mag_q;
	logic                out_step_q;
	gait_phase_t         out_phase_q;

	logic [SUM_W-1:0]    trial;
	logic                take;
	logic [PROD_W-1:0]   prod;
	logic [LEVEL_W-1:0]  dyn;
	logic [TIME_W-1:0]   since_entry;
	logic [TIME_W-1:0]   since_step;
	logic                settled;
	logic                commit;
	gait_phase_t         phase_nx;
	logic                entry_set;
	logic                step_nx;

	assign fifo_pop = (state_q == BK_IDLE) && !fifo_empty;
	assign commit   = (state_q == BK_COMMIT) && (!out_valid_q || m_tready);

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {5'd0, out_phase_q, out_step_q, out_mag_q};

	// One step of the restoring square root per cycle.
	assign trial = root_q + bit_q;
	assign take  = (rem_q >= trial);

	assign prod = PROD_W'(scaled_q) * PROD_W'(RECIP_TEN);

	assign dyn = (quot_q >= GRAVITY_Q88) ? quot_q - GRAVITY_Q88 : GRAVITY_Q88 - quot_q;
	assign since_entry = now_q - entry_q;
	assign since_step  = now_q - last_step_q;
	assign settled     = (since_entry >= TIME_W'(cfg.debounce_ms));

	always_comb begin
		phase_nx  = phase_q;
		entry_set = 1'b0;
		step_nx   = 1'b0;
		unique case (phase_q)
			PH_LIFT: begin
				if (settled) begin
					priority if (dyn > cfg.air_level) begin
						phase_nx  = PH_AIR;
						entry_set = 1'b1;
					end else if (dyn < cfg.lift_level) begin
						phase_nx = PH_STABLE;
					end else begin
						phase_nx = PH_LIFT;
					end
				end
			end
			PH_AIR: begin
				if (settled && dyn > cfg.impact_level &&
						since_step > TIME_W'(cfg.cooldown_ms)) begin
					phase_nx  = PH_STABLE;
					entry_set = 1'b1;
					step_nx   = 1'b1;
				end
			end
			default: begin
				if (dyn > cfg.lift_level) begin
					phase_nx  = PH_LIFT;
					entry_set = 1'b1;
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= BK_IDLE;
			iter_q      <= '0;
			filt_q      <= '0;
			phase_q     <= PH_STABLE;
			entry_q     <= '0;
			last_step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (commit) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				BK_IDLE: begin
					if (!fifo_empty) begin
						state_q <= BK_ROOT;
						iter_q  <= '0;
					end
				end
				BK_ROOT: begin
					iter_q <= iter_q + 4'd1;
					if (iter_q == 4'd15) begin
						state_q <= BK_SCALE;
					end
				end
				BK_SCALE: state_q <= BK_DIV;
				BK_DIV:   state_q <= BK_COMMIT;
				BK_COMMIT: begin
					if (commit) begin
						state_q     <= BK_IDLE;
						filt_q      <= quot_q;
						phase_q     <= phase_nx;
						if (entry_set) begin
							entry_q <= now_q;
						end
						if (step_nx) begin
							last_step_q <= now_q;
						end
					end
				end
				default: state_q <= BK_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (fifo_pop) begin
			rem_q  <= fifo_data.sum_sq;
			root_q <= '0;
			bit_q  <= ROOT_BIT_TOP;
			now_q  <= fifo_data.now_ms;
		end
		if (state_q == BK_ROOT) begin
			if (take) begin
				rem_q  <= rem_q - trial;
				root_q <= (root_q >> 1) + bit_q;
			end else begin
				root_q <= root_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (state_q == BK_SCALE) begin
			// 9 * old + root, at most ten times the largest magnitude
			scaled_q <= {1'b0, filt_q, 3'b000} + SCALED_W'(filt_q) + SCALED_W'(root_q[15:0]);
		end
		if (state_q == BK_DIV) begin
			quot_q <= prod[RECIP_SHIFT +: LEVEL_W];
		end
		if (commit) begin
			out_mag_q   <= quot_q;
			out_step_q  <= step_nx;
			out_phase_q <= phase_nx;
		end
	end

	a_step_leaves_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_step_q) |-> (out_phase_q == PH_STABLE))
		else $error("step reported outside the stable phase");

	a_step_times_agree: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_step_q) |-> (last_step_q == entry_q))
		else $error("step time and phase entry time disagree after a step");

	a_filter_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		filt_q <= MAG_MAX)
		else $error("smoothed magnitude out of range");

	a_root_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == BK_SCALE) |-> (root_q <= SUM_W'(MAG_MAX)))
		else $error("square root out of range");

endmodule

[hw/rtl/accel_step_detector_top.sv]
// Top level of the accelerometer step detector: register port, front end, queue and back end.
`timescale 1ns / 1ps
// Each request carries one three-axis Q8.8 sample and its millisecond time, and gives exactly
// one result: the smoothed magnitude, a step flag and the gait phase after the sample. The front
// end squares the axes with one multiplier and hands the sum to a two-entry queue; the back end
// takes one request at a time through the sixteen iterations of its bit-serial square root and
// its filter, divide and commit states, waiting at commit until the output is taken. Registers
// must be written through the APB port while no request is in flight; the block does not enforce
// this. They reset to lift 512, air 1024, impact 2048, debounce 50 ms and cooldown 300 ms.
module accel_step_detector_top
	import asd_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [79:0] s_tdata,  // accel_x[15:0], accel_y[31:16], accel_z[47:32], now_ms[79:48]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [23:0] m_tdata   // smoothed_magnitude[15:0], step_seen[16], gait_phase[18:17]
);

	cfg_t     cfg_q;
	logic     wr_en;
	logic [2:0] reg_idx;
	sample_t  push_data;
	sample_t  pop_data;
	logic     push;
	logic     full;
	logic     pop;
	logic     empty;

	assign pready  = 1'b1;
	assign reg_idx = paddr[4:2];
	assign wr_en   = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.lift_level   <= 16'd512;
			cfg_q.air_level    <= 16'd1024;
			cfg_q.impact_level <= 16'd2048;
			cfg_q.debounce_ms  <= 16'd50;
			cfg_q.cooldown_ms  <= 16'd300;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_LIFT:     cfg_q.lift_level   <= pwdata[15:0];
				REG_AIR:      cfg_q.air_level    <= pwdata[15:0];
				REG_IMPACT:   cfg_q.impact_level <= pwdata[15:0];
				REG_DEBOUNCE: cfg_q.debounce_ms  <= pwdata[15:0];
				REG_COOLDOWN: cfg_q.cooldown_ms  <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_LIFT:     prdata = {16'd0, cfg_q.lift_level};
			REG_AIR:      prdata = {16'd0, cfg_q.air_level};
			REG_IMPACT:   prdata = {16'd0, cfg_q.impact_level};
			REG_DEBOUNCE: prdata = {16'd0, cfg_q.debounce_ms};
			REG_COOLDOWN: prdata = {16'd0, cfg_q.cooldown_ms};
			default:      prdata = '0;
		endcase
	end

	asd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.fifo_full (full),
		.fifo_push (push),
		.fifo_data (push_data)
	);

	asd_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (full),
		.pop       (pop),
		.empty     (empty),
		.pop_data  (pop_data)
	);

	asd_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.fifo_empty (empty),
		.fifo_data  (pop_data),
		.fifo_pop   (pop),
		.m_tvalid   (m_tvalid),
		.m_tready   (m_tready),
		.m_tdata    (m_tdata)
	);

endmodule

[verif/accel_step_detector_top_tb.sv]
// Self-checking testbench of the accelerometer step detector with a built-in behavioural predictor.
`timescale 1ns / 1ps
module accel_step_detector_top_tb;
	import asd_pkg::*;

	localparam int unsigned RESET_CYCLES      = 4;
	localparam int unsigned CYCLE_LIMIT       = 500_000;
	localparam int unsigned DRAIN_CYCLES      = 64;
	localparam int unsigned SETTING_COUNT     = 8;
	localparam int unsigned ITEMS_PER_SETTING = 145;
	localparam int unsigned STALL_SETTING     = 4;
	localparam int unsigned LONG_HOLD         = 600;
	localparam int unsigned REG_SLOTS         = 8;
	localparam logic [16:0] GRAVITY_LEVEL     = 17'd2509;

	typedef struct {
		logic [15:0] magnitude;
		logic        step;
		gait_phase_t phase;
	} step_result_t;

	class step_scoreboard;
		logic [15:0]  lift_lvl;
		logic [15:0]  air_lvl;
		logic [15:0]  impact_lvl;
		logic [15:0]  settle_ms;
		logic [15:0]  cool_ms;
		logic [16:0]  filt;
		gait_phase_t  gait;
		logic [31:0]  entry_ms;
		logic [31:0]  last_step_ms;
		step_result_t due[$];
		int unsigned  mismatches;

		function new();
			lift_lvl     = 16'd512;
			air_lvl      = 16'd1024;
			impact_lvl   = 16'd2048;
			settle_ms    = 16'd50;
			cool_ms      = 16'd300;
			filt         = '0;
			gait         = PH_STABLE;
			entry_ms     = '0;
			last_step_ms = '0;
			mismatches   = 0;
		endfunction

		function void set_level(input logic [2:0] idx, input logic [31:0] value);
			case (idx)
				REG_LIFT:     lift_lvl   = value[15:0];
				REG_AIR:      air_lvl    = value[15:0];
				REG_IMPACT:   impact_lvl = value[15:0];
				REG_DEBOUNCE: settle_ms  = value[15:0];
				REG_COOLDOWN: cool_ms    = value[15:0];
				default: ;
			endcase
		endfunction

		function logic [15:0] floor_root(input logic [31:0] n);
			logic [15:0] root;
			logic [15:0] trial;
			int          b;
			root = '0;
			for (b = 15; b >= 0; b--) begin
				trial = root | (16'd1 << b);
				if (32'(trial) * 32'(trial) <= n)
					root = trial;
			end
			return root;
		endfunction

		function void note_sample(input logic signed [15:0] ax, ay, az,
				input logic [31:0] stamp);
			int           sx;
			int           sy;
			int           sz;
			logic [31:0]  sq_sum;
			logic [35:0]  acc;
			logic [16:0]  dyn;
			logic [31:0]  in_phase;
			logic [31:0]  since_step;
			step_result_t r;
			sx = ax;
			sy = ay;
			sz = az;
			sq_sum = 32'(sx * sx) + 32'(sy * sy) + 32'(sz * sz);
			acc = 36'(filt) * 36'd9 + 36'(floor_root(sq_sum));
			filt = 17'(acc / 36'd10);
			dyn = (filt >= GRAVITY_LEVEL) ? filt - GRAVITY_LEVEL : GRAVITY_LEVEL - filt;
			in_phase = stamp - entry_ms;
			since_step = stamp - last_step_ms;
			r.step = 1'b0;
			case (gait)
				PH_LIFT: begin
					if (in_phase >= 32'(settle_ms)) begin
						if (dyn > 17'(air_lvl)) begin
							gait = PH_AIR;
							entry_ms = stamp;
						end else if (dyn < 17'(lift_lvl)) begin
							// Falling back keeps the time the lifting phase began.
							gait = PH_STABLE;
						end
					end
				end
				PH_AIR: begin
					if (in_phase >= 32'(settle_ms) && dyn > 17'(impact_lvl) &&
							since_step > 32'(cool_ms)) begin
						gait = PH_STABLE;
						entry_ms = stamp;
						last_step_ms = stamp;
						r.step = 1'b1;
					end
				end
				default: begin
					if (dyn > 17'(lift_lvl)) begin
						gait = PH_LIFT;
						entry_ms = stamp;
					end
				end
			endcase
			r.magnitude = filt[15:0];
			r.phase = gait;
			due.push_back(r);
		endfunction

		task report(input string msg);
			$display("[%0t] mismatch: %s", $time, msg);
			mismatches++;
		endtask

		task check_result(input logic [23:0] word);
			step_result_t want;
			if (due.size() == 0) begin
				report($sformatf("result %h arrived with no request pending", word));
				return;
			end
			want = due.pop_front();
			if (word[15:0] !== want.magnitude)
				report($sformatf("smoothed magnitude %0d, expected %0d",
					word[15:0], want.magnitude));
			if (word[16] !== want.step)
				report($sformatf("step flag %b, expected %b", word[16], want.step));
			if (word[18:17] !== want.phase)
				report($sformatf("gait phase %0d, expected %0d", word[18:17], want.phase));
		endtask

		function int pending();
			return due.size();
		endfunction
	endclass

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        psel     = 1'b0;
	logic        penable  = 1'b0;
	logic        pwrite   = 1'b0;
	logic [4:0]  paddr    = '0;
	logic [31:0] pwdata   = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [79:0] s_tdata  = '0;  // accel_x[15:0], accel_y[31:16], accel_z[47:32], now_ms[79:48]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [23:0] m_tdata;        // smoothed_magnitude[15:0], step_seen[16], gait_phase[18:17]

	step_scoreboard board = new();
	bit             src_idle_on  = 1'b1;
	bit             sink_idle_on = 1'b1;
	int unsigned    sink_hold    = 0;
	int unsigned    cycle_count  = 0;
	logic [31:0]    t_now        = '0;

	accel_step_detector_top dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		forever #10 clk = ~clk;
	end

	always @(posedge clk) cycle_count <= cycle_count + 1;

	initial begin
		wait (cycle_count >= CYCLE_LIMIT);
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int unsigned draw_gap(input bit enabled);
		return enabled ? $urandom_range(0, 6) : 0;
	endfunction

	function automatic logic signed [15:0] pick_rail();
		return $urandom_range(0, 1) ? 16'sh8000 : 16'sh7FFF;
	endfunction

	function automatic logic [15:0] pick_level(input int unsigned lo, input int unsigned hi);
		int unsigned roll;
		roll = $urandom_range(0, 7);
		if (roll == 0)
			return 16'h0000;
		if (roll == 1)
			return 16'hFFFF;
		return 16'($urandom_range(lo, hi));
	endfunction

	task automatic write_level(input logic [2:0] idx, input logic [31:0] value);
		@(posedge clk);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		board.set_level(idx, value);
	endtask

	task automatic send_sample(input logic signed [15:0] ax, ay, az, input logic [31:0] stamp);
		int unsigned pause;
		pause = draw_gap(src_idle_on);
		if (pause != 0) begin
			s_tvalid <= 1'b0;
			repeat (pause) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {stamp, az, ay, ax};
		do @(posedge clk); while (s_tready !== 1'b1);
		board.note_sample(ax, ay, az, stamp);
	endtask

	// Spreads a wanted magnitude over two axes with a little noise on the third.
	task automatic send_mag(input int mag, input int unsigned dt);
		int a;
		int b;
		int c;
		a = (3 * mag) / 5;
		c = (4 * mag) / 5;
		b = $urandom_range(0, 300);
		if ($urandom_range(0, 1)) a = -a;
		if ($urandom_range(0, 1)) b = -b;
		if ($urandom_range(0, 1)) c = -c;
		t_now += dt;
		case ($urandom_range(0, 2))
			0: send_sample(16'(a), 16'(b), 16'(c), t_now);
			1: send_sample(16'(c), 16'(a), 16'(b), t_now);
			default: send_sample(16'(b), 16'(c), 16'(a), t_now);
		endcase
	endtask

	task automatic send_burst(input int unsigned lo, input int unsigned hi, input int unsigned n);
		int unsigned dt;
		repeat (n) begin
			dt = ($urandom_range(0, 19) == 0) ? $urandom_range(26, 500) : $urandom_range(0, 25);
			send_mag(int'($urandom_range(lo, hi)), dt);
		end
	endtask

	task automatic run_walks(input int unsigned quota);
		int unsigned sent;
		int unsigned kind;
		int unsigned n;
		sent = 0;
		while (sent < quota) begin
			if ($urandom_range(0, 4) == 0) src_idle_on = !src_idle_on;
			if ($urandom_range(0, 4) == 0) sink_idle_on = !sink_idle_on;
			if ($urandom_range(0, 9) == 0)
				t_now = $urandom_range(0, 1) ? $urandom : 32'hFFFF_FFFF - $urandom_range(0, 400);
			kind = $urandom_range(0, 9);
			if (kind < 7) begin
				// One stride: standing near gravity, push-off, free flight, heel strike.
				n = $urandom_range(3, 12);
				send_burst(2359, 2659, n);
				sent += n;
				n = $urandom_range(3, 12);
				send_burst(2809, 5009, n);
				sent += n;
				n = $urandom_range(3, 12);
				send_burst(0, 1500, n);
				sent += n;
				n = $urandom_range(3, 10);
				send_burst(5000, 40000, n);
				sent += n;
			end else if (kind < 9) begin
				n = $urandom_range(1, 8);
				repeat (n) begin
					if ($urandom_range(0, 1))
						t_now = $urandom;
					else
						t_now += $urandom_range(0, 1000);
					send_sample(16'($urandom), 16'($urandom), 16'($urandom), t_now);
				end
				sent += n;
			end else begin
				// Axes pinned at full scale drive the filter towards its ceiling.
				n = $urandom_range(10, 25);
				repeat (n) begin
					t_now += $urandom_range(0, 25);
					send_sample(pick_rail(), pick_rail(), pick_rail(), t_now);
				end
				sent += n;
			end
		end
	endtask

	task automatic choose_levels(input int unsigned k);
		logic [15:0] lift;
		logic [15:0] air;
		logic [15:0] impact;
		logic [15:0] settle;
		logic [15:0] cool;
		int unsigned slot;
		case (k)
			1: begin
				lift = 16'h0000; air = 16'h0000; impact = 16'h0000;
				settle = 16'h0000; cool = 16'h0000;
			end
			2: begin
				lift = 16'hFFFF; air = 16'hFFFF; impact = 16'hFFFF;
				settle = 16'hFFFF; cool = 16'hFFFF;
			end
			default: begin
				lift   = pick_level(100, 1200);
				air    = pick_level(600, 2500);
				impact = pick_level(500, 8000);
				settle = pick_level(0, 80);
				cool   = pick_level(0, 500);
			end
		endcase
		// The upper half of each write carries junk that the block must drop.
		write_level(REG_LIFT,     {16'($urandom), lift});
		write_level(REG_AIR,      {16'($urandom), air});
		write_level(REG_IMPACT,   {16'($urandom), impact});
		write_level(REG_DEBOUNCE, {16'($urandom), settle});
		write_level(REG_COOLDOWN, {16'($urandom), cool});
		for (slot = int'(REG_COOLDOWN) + 1; slot < REG_SLOTS; slot++)
			write_level(3'(slot), $urandom);
	endtask

	task automatic settle_block();
		s_tvalid <= 1'b0;
		do @(posedge clk); while (board.pending() != 0);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic run_directed();
		int unsigned i;
		send_sample(16'sd0, 16'sd0, 16'sd0, 32'h0000_0000);
		send_sample(16'sh8000, 16'sh8000, 16'sh8000, 32'hFFFF_FFFF);
		send_sample(16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 32'd30);
		send_sample(16'sh8000, 16'sh7FFF, 16'sd0, 32'd100);
		send_sample(16'sd0, 16'sd0, 16'sh8000, 32'd400);
		send_sample(16'sd1, -16'sd1, 16'sd0, 32'd401);
		send_sample(16'sd2509, 16'sd0, 16'sd0, 32'd402);
		send_sample(16'sd0, -16'sd2509, 16'sd0, 32'd450);
		send_sample(16'sd0, 16'sd0, 16'sd2509, 32'h8000_0000);
		send_sample(16'sh7FFF, 16'sd0, 16'sd0, 32'h7FFF_FFFF);
		send_sample(-16'sd1, -16'sd1, -16'sd1, 32'h8000_0032);
		send_sample(16'sh5555, 16'shAAAA, 16'sd0, 32'h5555_5555);
		send_sample(16'shAAAA, 16'sh5555, 16'shAAAA, 32'hAAAA_AAAA);
		t_now = 32'hFFFF_FFE0;
		for (i = 0; i < 7; i++) begin
			t_now += 32'd10;
			send_sample(16'sd0, 16'sd0, 16'sd2509, t_now);
		end
	endtask

	initial begin
		int unsigned k;
		wait (arst_n === 1'b1);
		forever begin
			if (sink_hold != 0) begin
				k = sink_hold;
				sink_hold = 0;
			end else begin
				k = draw_gap(sink_idle_on);
			end
			if (k != 0) begin
				m_tready <= 1'b0;
				repeat (k) @(posedge clk);
			end
			m_tready <= 1'b1;
			do @(posedge clk); while (m_tvalid !== 1'b1);
			board.check_result(m_tdata);
		end
	end

	initial begin
		int unsigned setting;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		run_directed();
		for (setting = 0; setting < SETTING_COUNT; setting++) begin
			settle_block();
			choose_levels(setting);
			// The long hold lets the queue fill so that the input side has to stall.
			if (setting == STALL_SETTING)
				sink_hold = LONG_HOLD;
			run_walks(ITEMS_PER_SETTING);
		end
		settle_block();
		if (board.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
